// ----- rtl/trwp_pkg.sv -----
// trwp_pkg: shared widths, codes and types of the timed register write player
// used by trwp_frame_store and timed_register_write_player; no dependencies
package trwp_pkg;

  localparam int unsigned FRAME_DEPTH_DEF = 8192;
  localparam int unsigned MAX_WRITES_DEF  = 64;

  localparam int IDX_W     = 13;
  localparam int POS_W     = 13;
  localparam int END_W     = 14;
  localparam int REG_W     = 8;
  localparam int VAL_W     = 8;
  localparam int WAIT_W    = 16;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_EXT_W = 21;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  typedef struct packed {
    logic [WAIT_W-1:0] wait_ticks;
    logic [REG_W-1:0]  reg_num;
    logic [VAL_W-1:0]  value;
  } frame_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    frame_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } store_req_t;

endpackage

// ----- rtl/trwp_frame_store.sv -----
// trwp_frame_store: single-port-per-direction frame memory, registered read
// depends on trwp_pkg for frame_t and store_req_t
module trwp_frame_store
  import trwp_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic       clk,
  input  store_req_t req,
  output frame_t     rd_data
);

  localparam int ADDR_W = $clog2(FRAME_DEPTH);

  frame_t mem [FRAME_DEPTH];
  frame_t rd_data_r;
  logic   rd_hit_r;

  logic [IDX_EXT_W-1:0] wr_ext;
  logic [IDX_EXT_W-1:0] rd_ext;
  logic                 wr_in_range;
  logic                 rd_in_range;

  assign wr_ext      = IDX_EXT_W'(req.wr_idx);
  assign rd_ext      = IDX_EXT_W'(req.rd_idx);
  assign wr_in_range = wr_ext < IDX_EXT_W'(FRAME_DEPTH);
  assign rd_in_range = rd_ext < IDX_EXT_W'(FRAME_DEPTH);

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in_range) begin
      mem[wr_ext[ADDR_W-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[rd_ext[ADDR_W-1:0]];
      rd_hit_r  <= rd_in_range;
    end
  end

  // beyond the store reads as an empty frame
  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

// ----- rtl/timed_register_write_player.sv -----
// timed_register_write_player: plays back frames as timed register writes
// depends on trwp_pkg and trwp_frame_store
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_we               | cfg_index, cfg_wdata
//  in      | in        | in_valid / in_ready  | op, frame index/register/value/wait
//  out     | out       | out_valid / out_ready| write register/value, last write
//
// load, start, stop and a tick with a running wait leave the block idle.
// a tick that plays frames starts a registered read of the frame memory;
// each frame read moves to the output register; a stalled output holds it.
// no new request is taken until the last write of a tick is in the output
// register. reset is synchronous; the frame memory is not cleared.
module timed_register_write_player
  import trwp_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH         = FRAME_DEPTH_DEF,
  parameter int unsigned MAX_WRITES_PER_TICK = MAX_WRITES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [IDX_W-1:0]     in_frame_index,
  input  logic [REG_W-1:0]     in_frame_register,
  input  logic [VAL_W-1:0]     in_frame_value,
  input  logic [WAIT_W-1:0]    in_frame_wait,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [REG_W-1:0]     out_write_register,
  output logic [VAL_W-1:0]     out_write_value,
  output logic                 out_last_write
);

  localparam int CNT_W = $clog2(MAX_WRITES_PER_TICK + 1);

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  start_r;
  logic [END_W-1:0]  end_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic              running_r, running_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [REG_W-1:0]  out_reg_r, out_reg_nxt;
  logic [VAL_W-1:0]  out_val_r, out_val_nxt;
  logic              out_last_r, out_last_nxt;

  store_req_t        req;
  frame_t            rd_frame;
  op_t               op;
  logic              in_fire;
  logic              out_free;
  logic [END_W-1:0]  pos_inc;
  logic [POS_W-1:0]  pos_adv;
  logic [CNT_W-1:0]  cnt_inc;
  logic              last;

  trwp_frame_store #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_store (
    .clk    (clk),
    .req    (req),
    .rd_data(rd_frame)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign op       = op_t'(in_op);
  assign out_free = !out_valid_r || out_ready;

  // loop back on the linear position
  assign pos_inc = END_W'(pos_r) + END_W'(1);
  assign pos_adv = (pos_inc >= end_r || pos_inc[END_W-1]) ? start_r : pos_inc[POS_W-1:0];

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign last    = (rd_frame.wait_ticks != '0) || (cnt_inc == CNT_W'(MAX_WRITES_PER_TICK));

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    wait_nxt      = wait_r;
    running_nxt   = running_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_reg_nxt   = out_reg_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    req           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_LOAD: begin
              req.wr_en   = 1'b1;
              req.wr_idx  = in_frame_index;
              req.wr_data = '{wait_ticks: in_frame_wait, reg_num: in_frame_register,
                              value: in_frame_value};
            end
            OP_START: begin
              pos_nxt     = start_r;
              running_nxt = 1'b1;
            end
            OP_STOP: begin
              running_nxt = 1'b0;
            end
            OP_TICK: begin
              if (running_r) begin
                if (wait_r != '0) begin
                  wait_nxt = wait_r - WAIT_W'(1);
                end else begin
                  req.rd_en  = 1'b1;
                  req.rd_idx = pos_r;
                  cnt_nxt    = '0;
                  state_nxt  = ST_READ;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // read data holds until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_reg_nxt   = rd_frame.reg_num;
          out_val_nxt   = rd_frame.value;
          out_last_nxt  = last;
          pos_nxt       = pos_adv;
          cnt_nxt       = cnt_inc;
          if (last) begin
            wait_nxt  = (rd_frame.wait_ticks != '0) ? rd_frame.wait_ticks - WAIT_W'(1) : '0;
            state_nxt = ST_IDLE;
          end else begin
            req.rd_en  = 1'b1;
            req.rd_idx = pos_adv;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      wait_r      <= '0;
      running_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      end_r       <= END_W'(1);
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      wait_r      <= wait_nxt;
      running_r   <= running_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_INDEX: start_r <= cfg_wdata[POS_W-1:0];
          CFG_END_INDEX:   end_r   <= cfg_wdata[END_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_reg_r  <= out_reg_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_write_register = out_reg_r;
  assign out_write_value    = out_val_r;
  assign out_last_write     = out_last_r;

  a_read_only_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> running_r)
    else $error("frame read while not running");

  a_tick_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == OP_TICK && running_r && wait_r == '0) |=> (state_r == ST_READ))
    else $error("due tick did not start a frame read");

  a_write_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (cnt_r < CNT_W'(MAX_WRITES_PER_TICK)))
    else $error("write count per tick over the cap");

endmodule

// ----- tb/testbench.sv -----
// testbench for timed_register_write_player: loads songs of frames, plays them with
// start, stop and tick requests and checks every synth write against a local player model
// depends on trwp_pkg and the timed_register_write_player rtl
module testbench
  import trwp_pkg::*;
();

  localparam int IDX_MAX   = FRAME_DEPTH_DEF - 1;
  localparam int POS_LIMIT = 2 ** POS_W;

  typedef struct {
    op_t               op;
    logic [IDX_W-1:0]  frame_index;
    logic [REG_W-1:0]  frame_reg;
    logic [VAL_W-1:0]  frame_val;
    logic [WAIT_W-1:0] frame_wait;
  } player_req_t;

  typedef struct {
    logic [REG_W-1:0] wreg;
    logic [VAL_W-1:0] wval;
    logic             last;
  } synth_write_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_op;
  logic [IDX_W-1:0]     in_frame_index;
  logic [REG_W-1:0]     in_frame_register;
  logic [VAL_W-1:0]     in_frame_value;
  logic [WAIT_W-1:0]    in_frame_wait;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [REG_W-1:0]     out_write_register;
  logic [VAL_W-1:0]     out_write_value;
  logic                 out_last_write;

  player_req_t  cur_req = '{OP_LOAD, '0, '0, '0, '0};
  player_req_t  pending[$];
  synth_write_t writes_due[$];
  logic         req_taken = 1'b0;

  // player model state
  frame_t            song_mem [FRAME_DEPTH_DEF];
  logic [POS_W-1:0]  play_pos = '0;
  logic [WAIT_W-1:0] wait_left = '0;
  logic              playing = 1'b0;
  logic [POS_W-1:0]  cfg_start = '0;
  logic [END_W-1:0]  cfg_end = 1;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;
  bit  hold_request = 1'b0;
  int  errors = 0;
  int  queued = 0;
  int  writes_seen = 0;
  int  phases = 0;
  int  gen_lo = 0;
  int  gen_hi = 1;
  bit  zero_waits = 1'b0;

  assign in_op             = cur_req.op;
  assign in_frame_index    = cur_req.frame_index;
  assign in_frame_register = cur_req.frame_reg;
  assign in_frame_value    = cur_req.frame_val;
  assign in_frame_wait     = cur_req.frame_wait;

  timed_register_write_player dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_frame_index     (in_frame_index),
    .in_frame_register  (in_frame_register),
    .in_frame_value     (in_frame_value),
    .in_frame_wait      (in_frame_wait),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_write_register (out_write_register),
    .out_write_value    (out_write_value),
    .out_last_write     (out_last_write)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic apply_request(input player_req_t r);
    frame_t          f;
    int unsigned     n;
    logic [END_W-1:0] nxt;
    case (r.op)
      OP_LOAD: song_mem[r.frame_index] = {r.frame_wait, r.frame_reg, r.frame_val};
      OP_START: begin
        play_pos = cfg_start;
        playing = 1'b1;
      end
      OP_STOP: playing = 1'b0;
      default: begin
        if (playing) begin
          n = 0;
          while (wait_left == '0 && n < MAX_WRITES_DEF) begin
            f = song_mem[play_pos];
            wait_left = f.wait_ticks;
            n++;
            nxt = {1'b0, play_pos} + 1'b1;
            if (nxt >= cfg_end || nxt >= POS_LIMIT) nxt = {1'b0, cfg_start};
            play_pos = nxt[POS_W-1:0];
            writes_due.push_back('{f.reg_num, f.value,
                                   (wait_left != '0) || (n == MAX_WRITES_DEF)});
          end
          if (wait_left != '0) wait_left--;
        end
      end
    endcase
  endtask

  // monitor: register writes, accepted requests and synth writes
  always @(posedge clk) begin
    synth_write_t exp_w;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_START_INDEX) cfg_start = cfg_wdata[POS_W-1:0];
        else cfg_end = cfg_wdata[END_W-1:0];
      end
      if (out_valid && out_ready) begin
        writes_seen++;
        if (writes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected write: expected none, got reg %h val %h last %b",
                   $time, out_write_register, out_write_value, out_last_write);
        end else begin
          exp_w = writes_due.pop_front();
          if (exp_w.wreg !== out_write_register || exp_w.wval !== out_write_value ||
              exp_w.last !== out_last_write) begin
            errors++;
            $display("%0t: write mismatch: expected reg %h val %h last %b,%s",
                     $time, exp_w.wreg, exp_w.wval, exp_w.last, " got");
            $display("%0t:   got reg %h val %h last %b",
                     $time, out_write_register, out_write_value, out_last_write);
          end
        end
      end
      if (in_valid && in_ready) apply_request(cur_req);
      req_taken <= in_valid && in_ready;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req <= pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off so the block fills up and stalls its input
  initial begin
    wait (hold_request);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic queue_req(input op_t op, input int idx, input int rg, input int vl,
                           input int wt);
    player_req_t r;
    r.op = op;
    r.frame_index = idx[IDX_W-1:0];
    r.frame_reg = rg[REG_W-1:0];
    r.frame_val = vl[VAL_W-1:0];
    r.frame_wait = wt[WAIT_W-1:0];
    pending.push_back(r);
    queued++;
  endtask

  task automatic queue_ctrl(input op_t op);
    queue_req(op, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic bit in_song(input int idx);
    if (gen_hi <= gen_lo) return idx == gen_lo;
    return idx >= gen_lo && idx < gen_hi;
  endfunction

  function automatic int song_wait();
    if (zero_waits) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(12, 4);
    return $urandom_range(2);
  endfunction

  // frames that can be played keep short waits, the rest take any wait
  task automatic queue_load(input int idx);
    queue_req(OP_LOAD, idx, $urandom, $urandom, in_song(idx) ? song_wait() : $urandom);
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid || writes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_song(input int lo, input int hi);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_INDEX;
    cfg_wdata <= lo[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_END_INDEX;
    cfg_wdata <= hi[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_lo = lo;
    gen_hi = hi;
  endtask

  task automatic play_phase(input int lo, input int hi, input int n_rand, input bit zw,
                            input bit squeeze);
    int i, k, span;
    set_song(lo, hi);
    zero_waits = zw;
    case (phases % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
    phases++;
    span = (hi > lo) ? hi - lo : 1;
    for (i = 0; i < span; i++) queue_load(lo + i);
    queue_ctrl(OP_START);
    for (i = 0; i < n_rand; i++) begin
      k = $urandom_range(99);
      if (k < 55) queue_ctrl(OP_TICK);
      else if (k < 70) queue_load(lo + $urandom_range(span - 1));
      else if (k < 85) queue_load($urandom_range(IDX_MAX));
      else if (k < 93) queue_ctrl(OP_START);
      else queue_ctrl(OP_STOP);
    end
    if (squeeze) hold_request = 1'b1;
  endtask

  initial begin
    int lo, hi, base, rnd_phases;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // idle tick, write cap on a one-frame loop, wait counting, stop and restart
    queue_ctrl(OP_TICK);
    queue_req(OP_LOAD, 0, 8'hFF, 8'h00, 0);
    queue_req(OP_LOAD, IDX_MAX, 8'h00, 8'hFF, 16'hFFFF);
    queue_ctrl(OP_START);
    queue_ctrl(OP_TICK);
    queue_ctrl(OP_TICK);
    queue_req(OP_LOAD, 0, 8'h00, 8'hFF, 2);
    queue_ctrl(OP_TICK);
    queue_ctrl(OP_TICK);
    queue_ctrl(OP_TICK);
    queue_ctrl(OP_STOP);
    queue_ctrl(OP_TICK);
    queue_ctrl(OP_START);
    queue_ctrl(OP_TICK);
    queue_ctrl(OP_TICK);
    queue_ctrl(OP_STOP);

    base = queued;
    play_phase(8190, 8192, 8, 1'b0, 1'b0);
    play_phase(5, 0, 6, 1'b1, 1'b0);
    play_phase(100, 50, 8, 1'b0, 1'b0);
    play_phase(8191, 8192, 8, 1'b0, 1'b0);
    rnd_phases = 0;
    while (queued - base < 220) begin
      lo = $urandom_range(IDX_MAX);
      if ($urandom_range(3) == 0) hi = $urandom_range(lo);
      else hi = lo + $urandom_range(8, 1);
      if (hi > POS_LIMIT) hi = POS_LIMIT;
      play_phase(lo, hi, $urandom_range(30, 15), rnd_phases == 2 || $urandom_range(4) == 0,
                 rnd_phases == 2);
      rnd_phases++;
    end

    // longest wait played last, since the counter then holds for the rest of the run
    set_song(8000, 8002);
    queue_req(OP_LOAD, 8000, 8'h5A, 8'hA5, 16'hFFFF);
    queue_req(OP_LOAD, 8001, 8'hA5, 8'h5A, 16'h8000);
    queue_ctrl(OP_START);
    queue_ctrl(OP_TICK);
    queue_ctrl(OP_TICK);
    queue_ctrl(OP_TICK);
    settle();
    repeat (20) @(posedge clk);

    $display("ran %0d requests over %0d song settings with idle and stall phases,",
             queued, phases + 1);
    $display("checked %0d synth writes including write-cap ticks and loop wraps", writes_seen);
    if (errors == 0 && writes_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- timed_register_write_player.f -----
rtl/trwp_pkg.sv
rtl/trwp_frame_store.sv
rtl/timed_register_write_player.sv
tb/testbench.sv
